### design/gsp_pkg.sv
// ============================================================================
// gsp_pkg: shared types and constants for the gate signal probability block
// Holds the sequencer state type, the gate codes and the fixed field widths.
// ============================================================================
package gsp_pkg;

    // Default number of fraction bits; 1.0 is 2**FRAC_BITS.
    localparam int FRAC_BITS_DEF = 16;

    // Fixed widths of the stream fields.
    localparam int PROB_W = 17;
    localparam int ACT_W  = 16;
    localparam int GATE_W = 3;

    // Packed widths of the stream data words, rounded up to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // Gate codes, in the order the results leave the block.
    typedef enum logic [GATE_W-1:0] {
        GATE_AND  = 3'd0,
        GATE_OR   = 3'd1,
        GATE_XOR  = 3'd2,
        GATE_NAND = 3'd3,
        GATE_NOR  = 3'd4
    } t_gate;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_AND,
        ST_MUL_NOR,
        ST_MUL_XOR,
        ST_RES_MUL,
        ST_RES_OUT
    } t_state;

endpackage

### design/gate_signal_probability.sv
// ============================================================================
// gate_signal_probability: gate output probability and switching activity
// Keeps running products over a run of input probabilities and, on the last
// input, emits AND, OR, XOR, NAND and NOR probabilities with their activity.
// ============================================================================
// Each input transaction is accepted from idle and then takes three passes
// through the single shared multiplier, one for each running product; no new
// input is accepted until they are done. A transaction flagged last then adds
// five results, each a multiplier pass for the activity and then a wait in the
// output register until the result is taken.
// Reset (synchronous, active low) returns all three products to 1.0.
module gate_signal_probability #(
    parameter int FRAC_BITS = gsp_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input stream.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: [16:0] prob, [23:17] zero.
    input  logic [gsp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tlast: last_input.
    input  logic                         s_axis_tlast,
    // Result stream.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tdata: [2:0] gate, [19:3] out_prob, [35:20] activity, [39:36] zero.
    output logic [gsp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tlast: last_result, set on the NOR result.
    output logic                         m_axis_tlast
);

    // Unsigned fixed point values up to 1.0 need FRAC_BITS+1 bits; the signed
    // XOR product spans -1.0 to 1.0 and needs one more.
    localparam int PW = FRAC_BITS + 1;
    localparam int XW = FRAC_BITS + 2;
    localparam int MW = 2 * PW;
    localparam int SW = MW + 1;

    localparam logic [PW-1:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [XW-1:0] ONE_X = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic [SW-1:0] HALF_S =
        {{(SW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    // Sequencer and running state.
    gsp_pkg::t_state r_state, n_state;
    gsp_pkg::t_gate  r_gate,  n_gate;
    logic [PW-1:0]   r_and,   n_and;
    logic [PW-1:0]   r_nor,   n_nor;
    logic [XW-1:0]   r_xor,   n_xor;
    logic [PW-1:0]   r_p,     n_p;
    logic            r_last,  n_last;

    // Output register.
    logic                       r_m_valid, n_m_valid;
    logic [gsp_pkg::PROB_W-1:0] r_out_prob, n_out_prob;
    logic [gsp_pkg::ACT_W-1:0]  r_act, n_act;

    // Shared multiplier with round-to-nearest rescaling.
    logic [PW-1:0] mul_a, mul_b;
    logic          mul_dbl;
    logic [MW-1:0] mul_prod;
    logic [SW-1:0] mul_sum;
    logic [PW-1:0] mul_rnd;

    // Datapath helpers.
    logic [31:0]   p_w;
    logic [31:0]   one_w;
    logic [PW-1:0] p_sat;
    logic [XW-1:0] factor;
    logic [XW-1:0] factor_mag_x;
    logic [XW-1:0] xor_mag_x;
    logic          xor_neg;
    logic [XW-1:0] xor_res;
    logic [XW-1:0] s_xor_x;
    logic [PW-1:0] s_sel;
    logic [31:0]   s_w;
    logic [31:0]   act_w;

    logic in_hs;
    logic out_hs;

    assign in_hs  = s_axis_tvalid && s_axis_tready;
    assign out_hs = r_m_valid && m_axis_tready;

    // Input probabilities above 1.0 are clamped to 1.0.
    assign p_w   = 32'(s_axis_tdata[gsp_pkg::PROB_W-1:0]);
    assign one_w = 32'(ONE);
    assign p_sat = (p_w > one_w) ? ONE : p_w[PW-1:0];

    // The XOR factor is 1 - 2p; its product is kept as a signed value and
    // multiplied in sign and magnitude form, so the rounding is symmetric.
    assign factor       = ONE_X - {r_p, 1'b0};
    assign factor_mag_x = factor[XW-1] ? (-factor) : factor;
    assign xor_mag_x    = r_xor[XW-1] ? (-r_xor) : r_xor;
    assign xor_neg      = r_xor[XW-1] ^ factor[XW-1];
    assign xor_res      = xor_neg ? (-XW'(mul_rnd)) : XW'(mul_rnd);

    // XOR probability is (1 - product) / 2, ties rounded up.
    assign s_xor_x = ONE_X - r_xor + XW'(1);

    // Probability of the gate currently being reported.
    always_comb begin
        case (r_gate)
            gsp_pkg::GATE_AND:  s_sel = r_and;
            gsp_pkg::GATE_OR:   s_sel = ONE - r_nor;
            gsp_pkg::GATE_XOR:  s_sel = s_xor_x[XW-1:1];
            gsp_pkg::GATE_NAND: s_sel = ONE - r_and;
            gsp_pkg::GATE_NOR:  s_sel = r_nor;
            default:            s_sel = r_nor;
        endcase
    end

    // The multiplier result is rescaled by FRAC_BITS with rounding; for the
    // activity the product is doubled first, giving 2s(1-s).
    assign mul_prod = MW'(mul_a) * MW'(mul_b);
    assign mul_sum  = (mul_dbl ? {mul_prod, 1'b0} : {1'b0, mul_prod}) + HALF_S;
    assign mul_rnd  = mul_sum[FRAC_BITS +: PW];

    // With more than sixteen fraction bits the outputs keep only the low bits.
    assign s_w   = 32'(s_sel);
    assign act_w = 32'(mul_rnd);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gsp_pkg::ST_IDLE: begin
                if (in_hs) begin
                    n_state = gsp_pkg::ST_MUL_AND;
                end
            end
            gsp_pkg::ST_MUL_AND: n_state = gsp_pkg::ST_MUL_NOR;
            gsp_pkg::ST_MUL_NOR: n_state = gsp_pkg::ST_MUL_XOR;
            gsp_pkg::ST_MUL_XOR: begin
                n_state = r_last ? gsp_pkg::ST_RES_MUL : gsp_pkg::ST_IDLE;
            end
            gsp_pkg::ST_RES_MUL: n_state = gsp_pkg::ST_RES_OUT;
            gsp_pkg::ST_RES_OUT: begin
                if (out_hs) begin
                    n_state = (r_gate == gsp_pkg::GATE_NOR) ?
                              gsp_pkg::ST_IDLE : gsp_pkg::ST_RES_MUL;
                end
            end
            default: n_state = gsp_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operands, handshakes and register updates.
    always_comb begin
        s_axis_tready = 1'b0;
        mul_a      = r_and;
        mul_b      = r_p;
        mul_dbl    = 1'b0;
        n_gate     = r_gate;
        n_and      = r_and;
        n_nor      = r_nor;
        n_xor      = r_xor;
        n_p        = r_p;
        n_last     = r_last;
        n_m_valid  = r_m_valid;
        n_out_prob = r_out_prob;
        n_act      = r_act;
        case (r_state)
            gsp_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_hs) begin
                    n_p    = p_sat;
                    n_last = s_axis_tlast;
                end
            end
            gsp_pkg::ST_MUL_AND: begin
                mul_a = r_and;
                mul_b = r_p;
                n_and = mul_rnd;
            end
            gsp_pkg::ST_MUL_NOR: begin
                mul_a = r_nor;
                mul_b = ONE - r_p;
                n_nor = mul_rnd;
            end
            gsp_pkg::ST_MUL_XOR: begin
                mul_a  = xor_mag_x[PW-1:0];
                mul_b  = factor_mag_x[PW-1:0];
                n_xor  = xor_res;
                n_gate = gsp_pkg::GATE_AND;
            end
            gsp_pkg::ST_RES_MUL: begin
                mul_a      = s_sel;
                mul_b      = ONE - s_sel;
                mul_dbl    = 1'b1;
                n_m_valid  = 1'b1;
                n_out_prob = s_w[gsp_pkg::PROB_W-1:0];
                n_act      = act_w[gsp_pkg::ACT_W-1:0];
            end
            gsp_pkg::ST_RES_OUT: begin
                if (out_hs) begin
                    n_m_valid = 1'b0;
                    if (r_gate == gsp_pkg::GATE_NOR) begin
                        // Run finished: every product goes back to 1.0.
                        n_and = ONE;
                        n_nor = ONE;
                        n_xor = ONE_X;
                    end else begin
                        n_gate = gsp_pkg::t_gate'(r_gate + 3'd1);
                    end
                end
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gsp_pkg::ST_IDLE;
            r_gate    <= gsp_pkg::GATE_AND;
            r_and     <= ONE;
            r_nor     <= ONE;
            r_xor     <= ONE_X;
            r_last    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_gate    <= n_gate;
            r_and     <= n_and;
            r_nor     <= n_nor;
            r_xor     <= n_xor;
            r_last    <= n_last;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_out_prob <= n_out_prob;
        r_act      <= n_act;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'd0, r_act, r_out_prob, r_gate};
    assign m_axis_tlast  = (r_gate == gsp_pkg::GATE_NOR);

`ifndef SYNTHESIS
    // A result is only ever offered from the output state.
    a_valid_in_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_state == gsp_pkg::ST_RES_OUT))
        else $error("result offered outside the output state");

    // The block never takes input while a result is pending.
    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_m_valid)
        else $error("input accepted while a result is pending");

    // Delivering the NOR result returns every product to 1.0.
    a_products_restored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_hs && (r_gate == gsp_pkg::GATE_NOR)) |=>
            ((r_and == ONE) && (r_nor == ONE) && (r_xor == ONE_X)
             && (r_state == gsp_pkg::ST_IDLE)))
        else $error("products not restored after the last result");

    // Results are reported in gate order, one code after another.
    a_gate_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_hs && (r_gate != gsp_pkg::GATE_NOR)) |=>
            (r_gate == gsp_pkg::t_gate'($past(r_gate) + 3'd1)))
        else $error("gate sequence broken");
`endif

endmodule
